// ===== rtl/tcw_pkg.sv =====
// Types and constants shared by the text console writer modules.
`default_nettype none
package tcw_pkg;

	localparam int ACTION_W       = 2;
	localparam int CHAR_W         = 8;
	localparam int COLUMN_FIELD_W = 7;
	localparam int ROW_FIELD_W    = 5;
	localparam int INDEX_W        = 11;
	localparam int LINEAR_FIELD_W = 11;
	localparam int WORD_W         = 16;
	localparam int ATTR_W         = 8;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [CHAR_W-1:0] BLANK_CHAR      = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR    = 8'h0A;
	localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE = 8'h07;

	typedef enum logic [APB_ADDR_W-1:0] {
		REG_TEXT_ATTRIBUTE = 3'd0
	} reg_addr_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUT_CHAR     = 2'd0,
		ACT_SET_CURSOR   = 2'd1,
		ACT_CLEAR_SCREEN = 2'd2,
		ACT_READ_CELL    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCROLL,
		ST_FILL,
		ST_READ_DATA,
		ST_LINEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		action_t                   action;
		logic [CHAR_W-1:0]         char_code;
		logic [COLUMN_FIELD_W-1:0] target_column;
		logic [ROW_FIELD_W-1:0]    target_row;
		logic [INDEX_W-1:0]        cell_index;
	} cmd_t;

	typedef struct packed {
		logic [COLUMN_FIELD_W-1:0] cursor_column;
		logic [ROW_FIELD_W-1:0]    cursor_row;
		logic [LINEAR_FIELD_W-1:0] cursor_linear;
		logic [WORD_W-1:0]         cell_word;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tcw_apb.sv =====
// APB register block holding the text attribute byte.
`default_nettype none
module tcw_apb (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [tcw_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready,
	output logic      [tcw_pkg::ATTR_W-1:0]       attr
);

	localparam logic [tcw_pkg::APB_ADDR_W-1:0] ATTR_ADDR = tcw_pkg::REG_TEXT_ATTRIBUTE;

	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	logic                       wr_en;
	logic                       hit;

	assign pready = 1'b1;
	assign hit    = (paddr[tcw_pkg::APB_ADDR_W-1:2] == ATTR_ADDR[tcw_pkg::APB_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready && hit;
	assign attr   = attr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::RESET_ATTRIBUTE;
		end else if (wr_en) begin
			attr_q <= pwdata[tcw_pkg::ATTR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = tcw_pkg::APB_DATA_W'(attr_q);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/text_console_writer_top.sv =====
// Text console writer top level: command sequencer, cursor and cell store.
//
// A text-mode console over a COLUMNS x ROWS store of 16-bit cells (attribute
// in the high byte, character in the low byte). One command is taken at a
// time and gives one response with the cursor after the command. After reset
// the store is blanked by a pass over all COLUMNS*ROWS cells (2000 by default)
// during which no command is taken; the attribute register can be written
// meanwhile. set_cursor also recomputes the linear cursor, read_cell skips
// the read when the index lies past the store, clear_screen blanks every
// cell, and a put_char at the end of the last row, or a newline on it,
// scrolls every row up and then blanks the last row: every cell move goes
// through the one read and one write port of the store, one cell a cycle. A
// response still held by rsp_stall delays the next response and command.
`default_nettype none
module text_console_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_valid,
	output logic                                 cmd_stall,
	input  wire tcw_pkg::cmd_t                   cmd,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output tcw_pkg::rsp_t                        rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [tcw_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready
);

	localparam int N_CELLS       = COLUMNS * ROWS;
	localparam int COL_W         = $clog2(COLUMNS);
	localparam int ROW_W         = $clog2(ROWS);
	localparam int ADDR_W        = $clog2(N_CELLS);
	localparam int CNT_W         = $clog2(N_CELLS + 1);
	localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

	tcw_pkg::state_t state_q, state_next;
	tcw_pkg::cmd_t   cmd_q;
	tcw_pkg::rsp_t   rsp_q;
	logic            rsp_valid_q;
	logic            init_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] lin_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] wa_q;
	logic              pend_q;
	logic [tcw_pkg::WORD_W-1:0] fill_word_q;
	logic [tcw_pkg::WORD_W-1:0] word_q;

	logic [tcw_pkg::ATTR_W-1:0] attr;
	logic [tcw_pkg::WORD_W-1:0] blank_word;
	logic [CNT_W-1:0]           scroll_dst;

	logic                       ram_we;
	logic [ADDR_W-1:0]          ram_waddr;
	logic [tcw_pkg::WORD_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [ADDR_W-1:0]          ram_raddr;
	logic [tcw_pkg::WORD_W-1:0] ram_rdata;

	logic is_newline;
	logic last_col;
	logic last_row;
	logic idx_ok;
	logic scroll_done;
	logic fill_done;
	logic rsp_free;

	tcw_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.attr    (attr)
	);

	tcw_ram #(
		.WIDTH (tcw_pkg::WORD_W),
		.DEPTH (N_CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign blank_word  = {attr, tcw_pkg::BLANK_CHAR};
	assign scroll_dst  = cnt_q - CNT_W'(COLUMNS);
	assign is_newline  = (cmd_q.char_code == tcw_pkg::NEWLINE_CHAR);
	assign last_col    = (col_q == COL_W'(COLUMNS - 1));
	assign last_row    = (row_q == ROW_W'(ROWS - 1));
	assign idx_ok      = (int'(cmd_q.cell_index) < N_CELLS);
	assign scroll_done = (cnt_q == CNT_W'(N_CELLS));
	assign fill_done   = (cnt_q == CNT_W'(N_CELLS - 1));
	assign rsp_free    = !rsp_valid_q || !rsp_stall;

	assign cmd_stall = (state_q != tcw_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			tcw_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_next = tcw_pkg::ST_DISPATCH;
				end
			end
			tcw_pkg::ST_DISPATCH: begin
				unique case (cmd_q.action)
					tcw_pkg::ACT_PUT_CHAR: begin
						if (last_row && (is_newline || last_col)) begin
							state_next = tcw_pkg::ST_SCROLL;
						end else begin
							state_next = tcw_pkg::ST_DONE;
						end
					end
					tcw_pkg::ACT_SET_CURSOR:   state_next = tcw_pkg::ST_LINEAR;
					tcw_pkg::ACT_CLEAR_SCREEN: state_next = tcw_pkg::ST_FILL;
					tcw_pkg::ACT_READ_CELL: begin
						state_next = idx_ok ? tcw_pkg::ST_READ_DATA : tcw_pkg::ST_DONE;
					end
					default: state_next = tcw_pkg::ST_DONE;
				endcase
			end
			tcw_pkg::ST_SCROLL: begin
				if (scroll_done) begin
					state_next = tcw_pkg::ST_FILL;
				end
			end
			tcw_pkg::ST_FILL: begin
				if (fill_done) begin
					state_next = init_q ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_READ_DATA: state_next = tcw_pkg::ST_DONE;
			tcw_pkg::ST_LINEAR:    state_next = tcw_pkg::ST_DONE;
			tcw_pkg::ST_DONE: begin
				if (rsp_free) begin
					state_next = tcw_pkg::ST_IDLE;
				end
			end
			default: state_next = tcw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = lin_q;
		ram_wdata = {attr, cmd_q.char_code};
		ram_re    = 1'b0;
		ram_raddr = ADDR_W'(cmd_q.cell_index);
		unique case (state_q)
			tcw_pkg::ST_DISPATCH: begin
				if (cmd_q.action == tcw_pkg::ACT_PUT_CHAR && !is_newline) begin
					ram_we = 1'b1;
				end
				if (cmd_q.action == tcw_pkg::ACT_READ_CELL && idx_ok) begin
					ram_re = 1'b1;
				end
			end
			tcw_pkg::ST_SCROLL: begin
				ram_we    = pend_q;
				ram_waddr = wa_q;
				ram_wdata = ram_rdata;
				ram_re    = !scroll_done;
				ram_raddr = cnt_q[ADDR_W-1:0];
			end
			tcw_pkg::ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[ADDR_W-1:0];
				ram_wdata = fill_word_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_FILL;
			init_q      <= 1'b1;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			fill_word_q <= {tcw_pkg::RESET_ATTRIBUTE, tcw_pkg::BLANK_CHAR};
			col_q       <= '0;
			row_q       <= '0;
			lin_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == tcw_pkg::ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				tcw_pkg::ST_DISPATCH: begin
					unique case (cmd_q.action)
						tcw_pkg::ACT_PUT_CHAR: begin
							if (is_newline || last_col) begin
								col_q <= '0;
								if (last_row) begin
									lin_q  <= ADDR_W'(LAST_ROW_BASE);
									cnt_q  <= CNT_W'(COLUMNS);
									pend_q <= 1'b0;
								end else begin
									row_q <= row_q + ROW_W'(1);
									lin_q <= lin_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS);
								end
							end else begin
								col_q <= col_q + COL_W'(1);
								lin_q <= lin_q + ADDR_W'(1);
							end
						end
						tcw_pkg::ACT_SET_CURSOR: begin
							col_q <= (int'(cmd_q.target_column) >= COLUMNS) ?
								COL_W'(COLUMNS - 1) : COL_W'(cmd_q.target_column);
							row_q <= (int'(cmd_q.target_row) >= ROWS) ?
								ROW_W'(ROWS - 1) : ROW_W'(cmd_q.target_row);
						end
						tcw_pkg::ACT_CLEAR_SCREEN: begin
							col_q       <= '0;
							row_q       <= '0;
							lin_q       <= '0;
							cnt_q       <= '0;
							fill_word_q <= blank_word;
						end
						default: begin
						end
					endcase
				end
				tcw_pkg::ST_SCROLL: begin
					pend_q <= !scroll_done;
					if (scroll_done) begin
						cnt_q       <= CNT_W'(LAST_ROW_BASE);
						fill_word_q <= blank_word;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				tcw_pkg::ST_FILL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (fill_done) begin
						init_q <= 1'b0;
					end
				end
				tcw_pkg::ST_LINEAR: begin
					lin_q <= ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcw_pkg::ST_IDLE && cmd_valid) begin
			cmd_q  <= cmd;
			word_q <= '0;
		end
		if (state_q == tcw_pkg::ST_SCROLL) begin
			wa_q <= scroll_dst[ADDR_W-1:0];
		end
		if (state_q == tcw_pkg::ST_READ_DATA) begin
			word_q <= ram_rdata;
		end
		if (state_q == tcw_pkg::ST_DONE && rsp_free) begin
			rsp_q.cursor_column <= tcw_pkg::COLUMN_FIELD_W'(col_q);
			rsp_q.cursor_row    <= tcw_pkg::ROW_FIELD_W'(row_q);
			rsp_q.cursor_linear <= tcw_pkg::LINEAR_FIELD_W'(lin_q);
			rsp_q.cell_word     <= word_q;
		end
	end

endmodule
`default_nettype wire
